[hw/rtl/spft_pkg.sv]
// Shared types and constants for the stroke point frame transform.
// No dependencies; imported by every module of the block.
package spft_pkg;

  // Pipeline depth: input register through output register.
  localparam int unsigned NUM_STAGES = 7;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_REF_ORIGIN      = 3'd0,
    REG_REF_ROTATION    = 3'd1,
    REG_AXIS_GAIN       = 3'd2,
    REG_TARGET_ROTATION = 3'd3,
    REG_TARGET_ORIGIN   = 3'd4,
    REG_PRESSURE_GAIN   = 3'd5
  } spft_reg_t;

  // Reset values: origins 0, rotations cos 1.0 / sin 0, gains 1.0.
  localparam logic [63:0] RST_REF_ORIGIN      = 64'h0;
  localparam logic [31:0] RST_REF_ROTATION    = 32'h4000_0000;
  localparam logic [63:0] RST_AXIS_GAIN       = 64'h0001_0000_0001_0000;
  localparam logic [31:0] RST_TARGET_ROTATION = 32'h4000_0000;
  localparam logic [63:0] RST_TARGET_ORIGIN   = 64'h0;
  localparam logic [15:0] RST_PRESSURE_GAIN   = 16'h0100;

  // Clamp bounds for the scaled intermediate, +/-(2^47 - 1).
  localparam logic signed [53:0] Q_HI = 54'sh00_7FFF_FFFF_FFFF;
  localparam logic signed [53:0] Q_LO = -54'sh00_7FFF_FFFF_FFFF;

  // Full register set as seen by the datapath.
  typedef struct packed {
    logic [63:0] ref_origin;
    logic [31:0] ref_rotation;
    logic [63:0] axis_gain;
    logic [31:0] target_rotation;
    logic [63:0] target_origin;
    logic [15:0] pressure_gain;
  } spft_cfg_t;

endpackage

[hw/rtl/stroke_point_frame_transform_top.sv]
// Top level of the stroke point frame transform.
// Depends on spft_pkg, spft_cfg_regs, spft_pipe_ctrl and spft_datapath.
//
// Transforms one stroke point per clock: offset by the reference origin,
// rotate by minus the reference angle, scale per axis, rotate by the target
// angle, offset by the target origin, and scale the pressure; every clip
// raises out_saturated. A point passes through the seven register stages of
// the datapath (one multiplier rank or one wide add per stage). A new point
// is taken every cycle while the output is not stalled; when it is stalled,
// empty stages keep filling until all seven hold a word. cfg_ready
// is always high; write registers only while no point is in flight.
module stroke_point_frame_transform_top import spft_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pt_x,
  input  logic signed [31:0] in_pt_y,
  input  logic [15:0]        in_pt_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_u,
  output logic signed [31:0] out_v,
  output logic [15:0]        out_pressure,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  spft_cfg_t             cfg;
  logic [NUM_STAGES-1:0] stage_en;

  // Register file
  spft_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage valids and stall handling
  spft_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  // Arithmetic
  spft_datapath u_dp (
    .clk            (clk),
    .stage_en       (stage_en),
    .cfg            (cfg),
    .in_pt_x        (in_pt_x),
    .in_pt_y        (in_pt_y),
    .in_pt_pressure (in_pt_pressure),
    .out_u          (out_u),
    .out_v          (out_v),
    .out_pressure   (out_pressure),
    .out_saturated  (out_saturated)
  );

endmodule

[hw/rtl/spft_cfg_regs.sv]
// Configuration register file of the stroke point frame transform.
// Depends on spft_pkg for the register indexes, reset values and struct.
module spft_cfg_regs import spft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output spft_cfg_t   cfg
);

  spft_cfg_t cfg_r;
  spft_cfg_t cfg_nxt;

  // Always take a write; unknown indexes drop the word.
  assign cfg_ready = 1'b1;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (spft_reg_t'(cfg_index))
        REG_REF_ORIGIN:      cfg_nxt.ref_origin      = cfg_data;
        REG_REF_ROTATION:    cfg_nxt.ref_rotation    = cfg_data[31:0];
        REG_AXIS_GAIN:       cfg_nxt.axis_gain       = cfg_data;
        REG_TARGET_ROTATION: cfg_nxt.target_rotation = cfg_data[31:0];
        REG_TARGET_ORIGIN:   cfg_nxt.target_origin   = cfg_data;
        REG_PRESSURE_GAIN:   cfg_nxt.pressure_gain   = cfg_data[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_origin      <= RST_REF_ORIGIN;
      cfg_r.ref_rotation    <= RST_REF_ROTATION;
      cfg_r.axis_gain       <= RST_AXIS_GAIN;
      cfg_r.target_rotation <= RST_TARGET_ROTATION;
      cfg_r.target_origin   <= RST_TARGET_ORIGIN;
      cfg_r.pressure_gain   <= RST_PRESSURE_GAIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/spft_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the transform pipeline.
// Depends on spft_pkg for the stage count.
module spft_pipe_ctrl import spft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NUM_STAGES-1:0] stage_en
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;

  // A stage loads when it is empty or its word moves on; bubbles collapse.
  always_comb begin
    stage_en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  // Advance the valid bits with the data
  always_comb begin
    vld_nxt[0] = stage_en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = stage_en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

[hw/rtl/spft_datapath.sv]
// Seven-stage fixed-point datapath: offset, rotate, scale, rotate, offset,
// saturate, plus the pressure gain. Depends on spft_pkg.
module spft_datapath import spft_pkg::*; (
  input  logic                  clk,
  input  logic [NUM_STAGES-1:0] stage_en,
  input  spft_cfg_t             cfg,
  input  logic signed [31:0]    in_pt_x,
  input  logic signed [31:0]    in_pt_y,
  input  logic [15:0]           in_pt_pressure,
  output logic signed [31:0]    out_u,
  output logic signed [31:0]    out_v,
  output logic [15:0]           out_pressure,
  output logic                  out_saturated
);

  // Configuration fields split into operands
  logic signed [31:0] ref_ox, ref_oy, tgt_ox, tgt_oy;
  logic signed [15:0] ref_c, ref_s, tgt_c, tgt_s;
  logic signed [16:0] gain_xh, gain_xl, gain_yh, gain_yl;

  assign ref_ox  = $signed(cfg.ref_origin[63:32]);
  assign ref_oy  = $signed(cfg.ref_origin[31:0]);
  assign tgt_ox  = $signed(cfg.target_origin[63:32]);
  assign tgt_oy  = $signed(cfg.target_origin[31:0]);
  assign ref_c   = $signed(cfg.ref_rotation[31:16]);
  assign ref_s   = $signed(cfg.ref_rotation[15:0]);
  assign tgt_c   = $signed(cfg.target_rotation[31:16]);
  assign tgt_s   = $signed(cfg.target_rotation[15:0]);
  assign gain_xh = $signed({1'b0, cfg.axis_gain[63:48]});
  assign gain_xl = $signed({1'b0, cfg.axis_gain[47:32]});
  assign gain_yh = $signed({1'b0, cfg.axis_gain[31:16]});
  assign gain_yl = $signed({1'b0, cfg.axis_gain[15:0]});

  // ---- stage 0: offset from the reference origin, pressure product
  logic signed [32:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [31:0]        pp_r, pp_nxt;

  assign dx_nxt = 33'(in_pt_x) - 33'(ref_ox);
  assign dy_nxt = 33'(in_pt_y) - 33'(ref_oy);
  assign pp_nxt = 32'(in_pt_pressure) * 32'(cfg.pressure_gain);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      pp_r <= pp_nxt;
    end
  end

  // ---- stage 1: reference rotation products, pressure round and clip
  logic signed [48:0] m_xc_r, m_ys_r, m_yc_r, m_xs_r;
  logic signed [48:0] m_xc_nxt, m_ys_nxt, m_yc_nxt, m_xs_nxt;
  logic [31:0]        pr_sum;
  logic [15:0]        pr1_r, pr1_nxt;
  logic               ps1_r, ps1_nxt;

  assign m_xc_nxt = 49'(dx_r) * 49'(ref_c);
  assign m_ys_nxt = 49'(dy_r) * 49'(ref_s);
  assign m_yc_nxt = 49'(dy_r) * 49'(ref_c);
  assign m_xs_nxt = 49'(dx_r) * 49'(ref_s);
  assign pr_sum   = pp_r + 32'd128;
  assign ps1_nxt  = |pr_sum[31:24];
  assign pr1_nxt  = ps1_nxt ? 16'hFFFF : pr_sum[23:8];

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      m_xc_r <= m_xc_nxt;
      m_ys_r <= m_ys_nxt;
      m_yc_r <= m_yc_nxt;
      m_xs_r <= m_xs_nxt;
      pr1_r  <= pr1_nxt;
      ps1_r  <= ps1_nxt;
    end
  end

  // ---- stage 2: sum and round the rotation back to Q16.16
  logic signed [49:0] rsum_x, rsum_y;
  logic signed [35:0] rx_r, ry_r;
  logic [15:0]        pr2_r;
  logic               ps2_r;

  assign rsum_x = 50'(m_xc_r) + 50'(m_ys_r) + 50'sd8192;
  assign rsum_y = 50'(m_yc_r) - 50'(m_xs_r) + 50'sd8192;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      rx_r  <= rsum_x[49:14];
      ry_r  <= rsum_y[49:14];
      pr2_r <= pr1_r;
      ps2_r <= ps1_r;
    end
  end

  // ---- stage 3: gain products, split into integer and fraction halves
  logic signed [52:0] hx_r, lx_r, hy_r, ly_r;
  logic signed [52:0] hx_nxt, lx_nxt, hy_nxt, ly_nxt;
  logic [15:0]        pr3_r;
  logic               ps3_r;

  assign hx_nxt = 53'(rx_r) * 53'(gain_xh);
  assign lx_nxt = 53'(rx_r) * 53'(gain_xl);
  assign hy_nxt = 53'(ry_r) * 53'(gain_yh);
  assign ly_nxt = 53'(ry_r) * 53'(gain_yl);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      hx_r  <= hx_nxt;
      lx_r  <= lx_nxt;
      hy_r  <= hy_nxt;
      ly_r  <= ly_nxt;
      pr3_r <= pr2_r;
      ps3_r <= ps2_r;
    end
  end

  // ---- stage 4: combine halves, round, clamp to 48 bits
  logic signed [69:0] qsum_x, qsum_y;
  logic signed [53:0] qx_full, qy_full;
  logic signed [47:0] qx_nxt, qy_nxt, qx_r, qy_r;
  logic               qsat_x, qsat_y;
  logic [15:0]        pr4_r;
  logic               sat4_r;

  assign qsum_x  = $signed({hx_r[52], hx_r, 16'h0}) + 70'(lx_r) + 70'sd32768;
  assign qsum_y  = $signed({hy_r[52], hy_r, 16'h0}) + 70'(ly_r) + 70'sd32768;
  assign qx_full = qsum_x[69:16];
  assign qy_full = qsum_y[69:16];

  // Clamp the scaled point
  always_comb begin
    qsat_x = 1'b1;
    qsat_y = 1'b1;
    if (qx_full > Q_HI) begin
      qx_nxt = Q_HI[47:0];
    end else if (qx_full < Q_LO) begin
      qx_nxt = Q_LO[47:0];
    end else begin
      qx_nxt = qx_full[47:0];
      qsat_x = 1'b0;
    end
    if (qy_full > Q_HI) begin
      qy_nxt = Q_HI[47:0];
    end else if (qy_full < Q_LO) begin
      qy_nxt = Q_LO[47:0];
    end else begin
      qy_nxt = qy_full[47:0];
      qsat_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      pr4_r  <= pr3_r;
      sat4_r <= ps3_r | qsat_x | qsat_y;
    end
  end

  // ---- stage 5: target rotation products
  logic signed [63:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [63:0] p_xc_nxt, p_ys_nxt, p_xs_nxt, p_yc_nxt;
  logic [15:0]        pr5_r;
  logic               sat5_r;

  assign p_xc_nxt = 64'(qx_r) * 64'(tgt_c);
  assign p_ys_nxt = 64'(qy_r) * 64'(tgt_s);
  assign p_xs_nxt = 64'(qx_r) * 64'(tgt_s);
  assign p_yc_nxt = 64'(qy_r) * 64'(tgt_c);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      p_xc_r <= p_xc_nxt;
      p_ys_r <= p_ys_nxt;
      p_xs_r <= p_xs_nxt;
      p_yc_r <= p_yc_nxt;
      pr5_r  <= pr4_r;
      sat5_r <= sat4_r;
    end
  end

  // ---- stage 6: sum with the target origin folded in above the round
  // point, then clip to 32 bits
  logic signed [65:0] tsum_x, tsum_y;
  logic signed [51:0] tx, ty;
  logic signed [31:0] u_nxt, v_nxt, u_r, v_r;
  logic               tsat_x, tsat_y;
  logic [15:0]        pr6_r;
  logic               sat6_r;

  assign tsum_x = 66'(p_xc_r) - 66'(p_ys_r)
                + $signed({{20{tgt_ox[31]}}, tgt_ox, 14'h0}) + 66'sd8192;
  assign tsum_y = 66'(p_xs_r) + 66'(p_yc_r)
                + $signed({{20{tgt_oy[31]}}, tgt_oy, 14'h0}) + 66'sd8192;
  assign tx = tsum_x[65:14];
  assign ty = tsum_y[65:14];

  // Clip when the upper bits are not a pure sign extension
  always_comb begin
    tsat_x = 1'b1;
    tsat_y = 1'b1;
    if (!tx[51] && (|tx[50:31])) begin
      u_nxt = 32'sh7FFF_FFFF;
    end else if (tx[51] && !(&tx[50:31])) begin
      u_nxt = 32'sh8000_0000;
    end else begin
      u_nxt  = tx[31:0];
      tsat_x = 1'b0;
    end
    if (!ty[51] && (|ty[50:31])) begin
      v_nxt = 32'sh7FFF_FFFF;
    end else if (ty[51] && !(&ty[50:31])) begin
      v_nxt = 32'sh8000_0000;
    end else begin
      v_nxt  = ty[31:0];
      tsat_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      pr6_r  <= pr5_r;
      sat6_r <= sat5_r | tsat_x | tsat_y;
    end
  end

  assign out_u         = u_r;
  assign out_v         = v_r;
  assign out_pressure  = pr6_r;
  assign out_saturated = sat6_r;

endmodule

[hw/rtl/spft_checker.sv]
// Port-level checks of the stroke point frame transform, bound to the top.
// Depends on spft_pkg for the pipeline depth.
module spft_port_checks import spft_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_u,
  input logic signed [31:0] out_v,
  input logic [15:0]        out_pressure,
  input logic               out_saturated
);

  // One spare bit so an overfill shows instead of wrapping.
  localparam int unsigned CNT_W = $clog2(NUM_STAGES + 1) + 1;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track words in flight
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_u) && $stable(out_v)
      && $stable(out_pressure) && $stable(out_saturated))
    else $error("result word changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Never more words in flight than stages
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_STAGES))
    else $error("more words in flight than pipeline stages");

  // A result only appears for an accepted word
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result word without an accepted input");

  // With the output stage empty, the input is never blocked
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

endmodule

bind stroke_point_frame_transform_top spft_port_checks u_spft_checker (.*);
